// ===== design/psh_filter_pkg.sv =====
package psh_filter_pkg;

  localparam int unsigned CfgDataW   = 15;
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned PeakThrW   = 15;
  localparam int unsigned WidthThrW  = 12;

  // register indexes of the configuration port
  localparam logic [CfgIndexW-1:0] CFG_GROUP_PEAK_MIN   = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_MULTI_PEAK_MIN   = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_MULTI_WIDTH_MIN  = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_SINGLE_PEAK_MIN  = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_SINGLE_WIDTH_MIN = 3'd4;

  // reset values, Q.4 rounded down
  localparam logic [PeakThrW-1:0]  GROUP_PEAK_RST   = 15'd96;
  localparam logic [PeakThrW-1:0]  MULTI_PEAK_RST   = 15'd192;
  localparam logic [WidthThrW-1:0] MULTI_WIDTH_RST  = 12'd60;
  localparam logic [PeakThrW-1:0]  SINGLE_PEAK_RST  = 15'd160;
  localparam logic [WidthThrW-1:0] SINGLE_WIDTH_RST = 12'd57;

  localparam logic OP_HIT = 1'b0;
  localparam logic OP_END = 1'b1;

  localparam logic signed [15:0] AMP_MOST_NEG = 16'sh8000;
  localparam logic [7:0]         DOF_ONE      = 8'd1;

  typedef struct packed {
    logic               operation;
    logic [15:0]        hit_key;
    logic signed [15:0] hit_amplitude;
    logic [11:0]        hit_width;
    logic [7:0]         hit_dof;
    logic [7:0]         snippet_position;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        out_key;
    logic signed [15:0] out_amplitude;
    logic [11:0]        out_width;
    logic [7:0]         out_dof;
    logic               last_in_run;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        key;
    logic signed [15:0] amp;
    logic [11:0]        width;
    logic [7:0]         dof;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic store;
    logic clear;
    logic idx_clr;
    logic idx_inc;
    logic rd_en;
    logic load_pend;
    logic push_pend;
    logic push_last;
    logic drop_pend;
  } cmd_t;

  typedef struct packed {
    logic close;
    logic is_end;
    logic pass;
    logic pend_valid;
    logic out_free;
    logic idx_last;
  } sts_t;

endpackage

// ===== design/psh_filter_ctrl.sv =====
module psh_filter_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  psh_filter_pkg::sts_t sts_i,
  output psh_filter_pkg::cmd_t cmd_o
);
  import psh_filter_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STORE,
    S_READ,
    S_EVAL,
    S_FLUSH
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept  = 1'b1;
          cmd_o.idx_clr = 1'b1;
          if (sts_i.close) begin
            state_d = S_READ;
          end else if (!sts_i.is_end) begin
            state_d = S_STORE;
          end
        end
      end
      S_STORE: begin
        cmd_o.store = 1'b1;
        state_d     = S_IDLE;
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_EVAL;
      end
      S_EVAL: begin
        // a second selected hit has to push the held one out first
        if (!(sts_i.pass && sts_i.pend_valid && !sts_i.out_free)) begin
          if (sts_i.pass) begin
            cmd_o.load_pend = 1'b1;
            cmd_o.push_pend = sts_i.pend_valid;
          end
          cmd_o.idx_inc = 1'b1;
          state_d       = sts_i.idx_last ? S_FLUSH : S_READ;
        end
      end
      S_FLUSH: begin
        if (!sts_i.pend_valid || sts_i.out_free) begin
          cmd_o.push_pend = sts_i.pend_valid;
          cmd_o.push_last = 1'b1;
          cmd_o.drop_pend = 1'b1;
          cmd_o.clear     = 1'b1;
          state_d         = sts_i.is_end ? S_IDLE : S_STORE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/psh_filter_datapath.sv =====
module psh_filter_datapath #(
  parameter int unsigned MAX_HITS = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [psh_filter_pkg::CfgIndexW-1:0]     cfg_index_i,
  input  logic [psh_filter_pkg::CfgDataW-1:0]      cfg_data_i,
  input  psh_filter_pkg::in_item_t                 in_data_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output psh_filter_pkg::out_item_t                out_data_o,
  input  psh_filter_pkg::cmd_t                     cmd_i,
  output psh_filter_pkg::sts_t                     sts_o
);
  import psh_filter_pkg::*;

  localparam int unsigned CW = $clog2(MAX_HITS + 1);
  localparam int unsigned IW = $clog2(MAX_HITS);

  logic [PeakThrW-1:0]  group_peak_q, multi_peak_q, single_peak_q;
  logic [WidthThrW-1:0] multi_width_q, single_width_q;

  entry_t             mem_q [MAX_HITS];
  entry_t             rd_q;
  entry_t             pend_q;
  logic               pend_valid_q;
  in_item_t           item_q;
  logic [CW-1:0]      count_q;
  logic [IW-1:0]      idx_q;
  logic signed [15:0] max_q;
  logic [7:0]         prev_q;
  out_item_t          out_q;
  logic               out_valid_q;

  logic               out_free;
  logic               group_ok, multi_ok, single_ok;
  entry_t             wr_entry;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_peak_q   <= GROUP_PEAK_RST;
      multi_peak_q   <= MULTI_PEAK_RST;
      multi_width_q  <= MULTI_WIDTH_RST;
      single_peak_q  <= SINGLE_PEAK_RST;
      single_width_q <= SINGLE_WIDTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_GROUP_PEAK_MIN:   group_peak_q   <= cfg_data_i[PeakThrW-1:0];
        CFG_MULTI_PEAK_MIN:   multi_peak_q   <= cfg_data_i[PeakThrW-1:0];
        CFG_MULTI_WIDTH_MIN:  multi_width_q  <= cfg_data_i[WidthThrW-1:0];
        CFG_SINGLE_PEAK_MIN:  single_peak_q  <= cfg_data_i[PeakThrW-1:0];
        CFG_SINGLE_WIDTH_MIN: single_width_q <= cfg_data_i[WidthThrW-1:0];
        default: begin
        end
      endcase
    end
  end

  // signed amplitude against unsigned thresholds, both widened to 17 bits
  assign group_ok  = $signed({max_q[15], max_q}) > $signed({2'b00, group_peak_q});
  assign multi_ok  = (rd_q.dof == DOF_ONE) ||
                     (($signed({rd_q.amp[15], rd_q.amp}) > $signed({2'b00, multi_peak_q})) &&
                      (rd_q.width > multi_width_q));
  assign single_ok = ($signed({rd_q.amp[15], rd_q.amp}) > $signed({2'b00, single_peak_q})) &&
                     (rd_q.width > single_width_q);

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    sts_o            = '0;
    sts_o.close      = (count_q != '0) &&
                       ((in_data_i.operation == OP_END) || (prev_q >= in_data_i.snippet_position));
    sts_o.is_end     = (item_q.operation == OP_END);
    if (cmd_i.accept) begin
      sts_o.is_end = (in_data_i.operation == OP_END);
    end
    sts_o.pass       = (count_q == CW'(1)) ? single_ok : (group_ok && multi_ok);
    sts_o.pend_valid = pend_valid_q;
    sts_o.out_free   = out_free;
    sts_o.idx_last   = ({1'b0, idx_q} + (IW+1)'(1)) == (IW+1)'(count_q);
  end

  assign wr_entry = '{key:   item_q.hit_key,
                      amp:   item_q.hit_amplitude,
                      width: item_q.hit_width,
                      dof:   item_q.hit_dof};

  // snippet buffer, no reset: entries at or above the count are never read
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && (count_q < CW'(MAX_HITS))) begin
      mem_q[count_q[IW-1:0]] <= wr_entry;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[idx_q];
    end
    if (cmd_i.accept) begin
      item_q <= in_data_i;
    end
    if (cmd_i.load_pend) begin
      pend_q <= rd_q;
    end
    if (cmd_i.push_pend) begin
      out_q <= '{out_key:       pend_q.key,
                 out_amplitude: pend_q.amp,
                 out_width:     pend_q.width,
                 out_dof:       pend_q.dof,
                 last_in_run:   cmd_i.push_last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      max_q        <= AMP_MOST_NEG;
      prev_q       <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        prev_q <= (in_data_i.operation == OP_END) ? 8'd0 : in_data_i.snippet_position;
      end
      if (cmd_i.clear) begin
        count_q <= '0;
        max_q   <= AMP_MOST_NEG;
      end else if (cmd_i.store && (count_q < CW'(MAX_HITS))) begin
        count_q <= count_q + CW'(1);
        if (item_q.hit_amplitude > max_q) begin
          max_q <= item_q.hit_amplitude;
        end
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + IW'(1);
      end
      if (cmd_i.load_pend) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.drop_pend) begin
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.push_pend) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/pulse_snippet_hit_filter_unit.sv =====
// Groups fitted pulse hits into snippets (a hit whose snippet position is not above the
// previous one starts a new snippet) and, when a snippet closes, emits its selected hits
// in buffer order with last_in_run on the final one; an end-of-event beat closes the
// last snippet. Hits past MAX_HITS in one snippet are dropped. One beat is taken at a
// time: a hit that does not close a snippet is accepted and then written to the buffer;
// a closing beat is accepted, each buffered hit is read and evaluated, a flush pushes
// any held hit, then a closing hit is written; the walk waits while a push meets a
// stalled output. The single-port snippet buffer is walked one entry per read and
// evaluate pair. The output register lets the walk go on while a result waits to be taken.
module pulse_snippet_hit_filter_unit #(
  parameter int unsigned MAX_HITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [psh_filter_pkg::CfgIndexW-1:0] cfg_index_i,
  input  logic [psh_filter_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  psh_filter_pkg::in_item_t             in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output psh_filter_pkg::out_item_t            out_data_o
);
  import psh_filter_pkg::*;

  cmd_t cmd;
  sts_t sts;

  psh_filter_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psh_filter_datapath #(
    .MAX_HITS (MAX_HITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
